[design/bdhc_pkg.sv]
// Package for the buoyancy depth-hold controller.
// Holds the action codes, register indexes and reset constants of the top level;
// the action codes and full drive duty are also used by its port checker. No dependencies.
package bdhc_pkg;

    localparam int PRESSURE_BITS_DEF = 19;

    localparam int BAND_BITS   = 12;
    localparam int DUTY_BITS   = 8;
    localparam int MS_BITS     = 10;
    localparam int ACC_BITS    = 11;
    localparam int CFG_IDX_BITS = 3;

    localparam int TARGET_RESET    = 10550;
    localparam int START_RESET     = 10230;
    localparam int ERR_BAND_RESET  = 20;
    localparam int RECOVER_RESET   = 30;
    localparam int DEADBAND_RESET  = 50;
    localparam int DESCENT_RESET   = 20;
    localparam int SLOW_RESET      = 100;
    localparam int PERIOD_RESET    = 10;

    localparam logic [DUTY_BITS-1:0] FULL_DRIVE = 8'd255;
    localparam logic [ACC_BITS-1:0]  ACC_MAX    = 11'd2047;

    typedef enum logic [2:0] {
        ACT_STOP  = 3'd0,
        ACT_SINK  = 3'd1,
        ACT_RISE  = 3'd2,
        ACT_FLOAT = 3'd3,
        ACT_HOLD  = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TARGET   = 3'd0,
        REG_START    = 3'd1,
        REG_ERR_BAND = 3'd2,
        REG_RECOVER  = 3'd3,
        REG_DEADBAND = 3'd4,
        REG_DESCENT  = 3'd5,
        REG_SLOW     = 3'd6,
        REG_PERIOD   = 3'd7
    } cfg_idx_t;

endpackage

[design/buoyancy_depth_hold_controller_top.sv]
// Buoyancy depth-hold controller: pressure samples in, pump-motor duties out.
// Depends on bdhc_pkg.
//
// The block accepts one request per clock cycle unless the result side stalls, and
// returns one result per request, through an input register and then a result
// register. All controller state (mode latch, descent flag, sample timer, prior
// pressure, held drives, peak and trough trackers) is updated as the result
// register loads, so back-to-back requests see each other's state with no bubble.
// Configuration registers may be written only while no request is in flight.
module buoyancy_depth_hold_controller_top
    import bdhc_pkg::*;
#(
    parameter int PRESSURE_BITS = PRESSURE_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // s_tdata, from bit 0: pressure, elapsed_ms, auto_request, push_pin,
    // pull_pin, zero fill
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [((PRESSURE_BITS+13+7)/8)*8-1:0] s_tdata,
    // m_tdata, from bit 0: sink_drive, rise_drive, auto_active, action, zero fill
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [PRESSURE_BITS-1:0]  cfg_wdata
);

    localparam int PB  = PRESSURE_BITS;
    localparam int PW1 = PB + 1;
    localparam int PW2 = PB + 2;
    localparam int S_W = ((PB + 13 + 7) / 8) * 8;

    // Configuration registers
    logic [PB-1:0]        tgt_reg, start_reg;
    logic [BAND_BITS-1:0] eb_reg, rm_reg, db_reg, thr_reg;
    logic [DUTY_BITS-1:0] slow_reg;
    logic [MS_BITS-1:0]   period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_reg    <= PB'(TARGET_RESET);
            start_reg  <= PB'(START_RESET);
            eb_reg     <= BAND_BITS'(ERR_BAND_RESET);
            rm_reg     <= BAND_BITS'(RECOVER_RESET);
            db_reg     <= BAND_BITS'(DEADBAND_RESET);
            thr_reg    <= BAND_BITS'(DESCENT_RESET);
            slow_reg   <= DUTY_BITS'(SLOW_RESET);
            period_reg <= MS_BITS'(PERIOD_RESET);
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                REG_TARGET:   tgt_reg    <= cfg_wdata;
                REG_START:    start_reg  <= cfg_wdata;
                REG_ERR_BAND: eb_reg     <= cfg_wdata[BAND_BITS-1:0];
                REG_RECOVER:  rm_reg     <= cfg_wdata[BAND_BITS-1:0];
                REG_DEADBAND: db_reg     <= cfg_wdata[BAND_BITS-1:0];
                REG_DESCENT:  thr_reg    <= cfg_wdata[BAND_BITS-1:0];
                REG_SLOW:     slow_reg   <= cfg_wdata[DUTY_BITS-1:0];
                REG_PERIOD:   period_reg <= cfg_wdata[MS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Input stage
    logic               in_valid_reg;
    logic [PB-1:0]      p_reg;
    logic [MS_BITS-1:0] el_reg;
    logic               man_reg, push_reg, pull_reg;
    logic               out_valid_reg;
    logic               out_free;
    logic               fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            p_reg    <= s_tdata[PB-1:0];
            el_reg   <= s_tdata[PB+MS_BITS-1:PB];
            man_reg  <= s_tdata[PB+10];
            push_reg <= s_tdata[PB+11];
            pull_reg <= s_tdata[PB+12];
        end
    end

    // Controller state
    logic                 auto_reg, auto_next;
    logic                 done_reg, done_next;
    logic [ACC_BITS-1:0]  acc_reg, acc_next;
    logic [PB-1:0]        prior_reg, prior_next;
    logic [PB-1:0]        desc_reg, desc_next;
    logic [PB-1:0]        peak_reg, peak_next;
    logic [PB-1:0]        trough_reg, trough_next;
    logic [DUTY_BITS-1:0] sink_reg, sink_next;
    logic [DUTY_BITS-1:0] rise_reg, rise_next;
    action_t              act;

    logic [ACC_BITS:0]    acc_sum;
    logic [ACC_BITS-1:0]  acc_sat;
    logic                 refresh;
    logic [PB-1:0]        prior_eff;
    logic [PW1-1:0]       p_w, tgt_w, db_w, thr_sum;
    logic                 descend_hit, in_window;
    logic [PB-1:0]        eb_w;
    logic [PB-1:0]        peak_gap, peak1, peak_diff;
    logic                 float_ok;
    logic [PW2-1:0]       np;
    logic [PB-1:0]        np_sat;
    logic [BAND_BITS:0]   off;
    logic [PB-1:0]        trough1, trough_diff, trough_rst;
    logic                 sink_ok;

    always_comb begin
        acc_sum   = {1'b0, acc_reg} + {{(ACC_BITS+1-MS_BITS){1'b0}}, el_reg};
        acc_sat   = (acc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_BITS-1:0];
        refresh   = acc_sat >= {{(ACC_BITS-MS_BITS){1'b0}}, period_reg};
        prior_eff = refresh ? p_reg : prior_reg;

        p_w     = {1'b0, p_reg};
        tgt_w   = {1'b0, tgt_reg};
        db_w    = {{(PW1-BAND_BITS){1'b0}}, db_reg};
        eb_w    = {{(PB-BAND_BITS){1'b0}}, eb_reg};
        thr_sum = {1'b0, prior_eff} + {{(PW1-BAND_BITS){1'b0}}, thr_reg};
        descend_hit = p_w > thr_sum;
        in_window   = ((p_w + db_w) > tgt_w) && (p_w < (tgt_w + db_w));

        peak_gap  = p_reg - peak_reg;
        peak1     = ((peak_reg < p_reg) && (peak_gap < eb_w)) ? p_reg : peak_reg;
        peak_diff = peak1 - p_reg;
        float_ok  = (peak1 <= p_reg) || (peak_diff <= eb_w);
        np        = {2'b00, p_reg} + {{(PW2-BAND_BITS){1'b0}}, eb_reg}
                    + {{(PW2-BAND_BITS){1'b0}}, rm_reg};
        np_sat    = (np > {2'b00, {PB{1'b1}}}) ? {PB{1'b1}} : np[PB-1:0];

        trough1     = ((trough_reg > p_reg) && (p_reg < desc_reg)) ? p_reg : trough_reg;
        trough_diff = p_reg - trough1;
        sink_ok     = (p_reg <= trough1) || (trough_diff <= eb_w);
        off         = {1'b0, eb_reg} + {1'b0, rm_reg};
        trough_rst  = (p_w > {{(PW1-BAND_BITS-1){1'b0}}, off})
                      ? (p_reg - {{(PB-BAND_BITS-1){1'b0}}, off}) : '0;

        acc_next    = refresh ? '0 : acc_sat;
        prior_next  = prior_eff;
        auto_next   = auto_reg;
        done_next   = done_reg;
        desc_next   = desc_reg;
        peak_next   = peak_reg;
        trough_next = trough_reg;
        sink_next   = '0;
        rise_next   = '0;
        act         = ACT_STOP;

        if (!auto_reg) begin
            if (man_reg) begin
                auto_next = 1'b1;
                sink_next = sink_reg;
                rise_next = rise_reg;
                act       = ACT_HOLD;
            end else if (!pull_reg && push_reg) begin
                sink_next = FULL_DRIVE;
                act       = ACT_SINK;
            end else if (pull_reg && !push_reg) begin
                rise_next = FULL_DRIVE;
                act       = ACT_RISE;
            end
        end else if (p_reg < start_reg) begin
            act = ACT_STOP;
        end else if (!done_reg) begin
            if (descend_hit) begin
                desc_next = p_reg;
                done_next = 1'b1;
            end else begin
                sink_next = FULL_DRIVE;
                act       = ACT_SINK;
            end
        end else if (in_window) begin
            act = ACT_STOP;
        end else if (p_reg > tgt_reg) begin
            trough_next = tgt_reg;
            if (float_ok) begin
                peak_next = peak1;
                rise_next = slow_reg;
                act       = ACT_FLOAT;
            end else begin
                peak_next = np_sat;
            end
        end else begin
            peak_next = tgt_reg;
            if (sink_ok) begin
                trough_next = trough1;
                sink_next   = slow_reg;
                act         = ACT_SINK;
            end else begin
                trough_next = trough_rst;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_reg   <= 1'b0;
            done_reg   <= 1'b0;
            acc_reg    <= '0;
            prior_reg  <= '0;
            desc_reg   <= '0;
            peak_reg   <= PB'(TARGET_RESET);
            trough_reg <= PB'(TARGET_RESET);
            sink_reg   <= '0;
            rise_reg   <= '0;
        end else if (fire) begin
            auto_reg   <= auto_next;
            done_reg   <= done_next;
            acc_reg    <= acc_next;
            prior_reg  <= prior_next;
            desc_reg   <= desc_next;
            peak_reg   <= peak_next;
            trough_reg <= trough_next;
            sink_reg   <= sink_next;
            rise_reg   <= rise_next;
        end
    end

    // Result stage
    logic [DUTY_BITS-1:0] out_sink_reg, out_rise_reg;
    logic                 out_auto_reg;
    action_t              out_act_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_sink_reg <= sink_next;
            out_rise_reg <= rise_next;
            out_auto_reg <= auto_next;
            out_act_reg  <= act;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_act_reg, out_auto_reg, out_rise_reg, out_sink_reg};

    logic unused_pad;
    assign unused_pad = ^{s_tdata[S_W-1:PB+12], 1'b0};

endmodule

[design/bdhc_checker.sv]
// Port checker for the buoyancy depth-hold controller, bound to the top level.
// Depends on bdhc_pkg and buoyancy_depth_hold_controller_top.
module bdhc_checker
    import bdhc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic [7:0] sink_f, rise_f;
    logic       auto_f;
    logic [2:0] act_f;
    logic       seen_auto_reg;

    assign sink_f = m_tdata[7:0];
    assign rise_f = m_tdata[15:8];
    assign auto_f = m_tdata[16];
    assign act_f  = m_tdata[19:17];

    // Auto mode, once reported, stays latched until reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_auto_reg <= 1'b0;
        end else if (m_tvalid && m_tready && auto_f) begin
            seen_auto_reg <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_auto_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_auto_reg |-> auto_f)
        else $error("auto mode dropped after it was latched");

    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (act_f == ACT_STOP) |-> (sink_f == 8'd0) && (rise_f == 8'd0))
        else $error("stop result with motor drive");

    a_rise_manual: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (act_f == ACT_RISE) |-> !auto_f && (rise_f == FULL_DRIVE)
            && (sink_f == 8'd0))
        else $error("rise result outside manual mode or with wrong duty");

    a_hold_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (act_f == ACT_HOLD) |-> auto_f && !seen_auto_reg)
        else $error("drive hold without a fresh auto latch");

endmodule

bind buoyancy_depth_hold_controller_top bdhc_checker u_bdhc_checker (.*);
